### hw/rtl/b32_pkg.sv
`default_nettype none

package b32_pkg;

  // One input request
  typedef struct packed {
    logic [7:0] prog_byte;
    logic [4:0] witness_version;
    logic       first_byte;
    logic       final_byte;
  } b32_item_t;

  // One result
  typedef struct packed {
    logic [6:0] out_char;
    logic       end_of_address;
  } b32_result_t;

  // Queue entry from front to back, already classified
  typedef struct packed {
    logic [7:0] prog_byte;
    logic [4:0] witness_version;
    logic       first_byte;
    logic       final_byte;
    logic       modern;
  } b32_cmd_t;

  // Handshake between front queue and back sequencer
  typedef struct packed {
    logic empty;
  } b32_qstat_t;

  typedef struct packed {
    logic pop;
  } b32_qctl_t;

  // Resolved configuration
  typedef struct packed {
    logic [3:0]  len_m1;
    logic [63:0] prefix_chars;
  } b32_cfg_t;

  // Configuration register indexes
  localparam logic REG_PREFIX_LENGTH = 1'b0;
  localparam logic REG_PREFIX_CHARS  = 1'b1;

  localparam logic [3:0]  PREFIX_LENGTH_RST = 4'd2;
  localparam logic [63:0] PREFIX_CHARS_RST  = 64'd25442;

  localparam logic [29:0] CHK_INIT       = 30'd1;
  localparam logic [29:0] BECH32_CONST   = 30'd1;
  localparam logic [29:0] BECH32M_CONST  = 30'h2bc830a3;

  localparam logic [29:0] GEN_POLY [5] = '{
    30'h3b6a57b2, 30'h26508e6d, 30'h1ea119fa, 30'h3d4233dd, 30'h2a1462b3
  };

  localparam logic [7:0] CHARSET [32] = '{
    "q", "p", "z", "r", "y", "9", "x", "8",
    "g", "f", "2", "t", "v", "d", "w", "0",
    "s", "3", "j", "n", "5", "4", "k", "h",
    "c", "e", "6", "m", "u", "a", "7", "l"
  };

  localparam logic [7:0] SEPARATOR = "1";

  // One step of the BCH polymod over GF(32)
  function automatic logic [29:0] b32_fold(logic [29:0] acc, logic [4:0] sym);
    logic [4:0]  top;
    logic [29:0] r;
    top = acc[29:25];
    r   = {acc[24:0], sym};
    for (int k = 0; k < 5; k++) begin
      if (top[k]) begin
        r = r ^ GEN_POLY[k];
      end
    end
    return r;
  endfunction

  function automatic logic [6:0] b32_char(logic [4:0] sym);
    logic [7:0] c;
    c = CHARSET[sym];
    return c[6:0];
  endfunction

endpackage

`default_nettype wire

### hw/rtl/b32_front.sv
`default_nettype none

module b32_front import b32_pkg::*; (
  input  wire             clk_i,
  input  wire             rst_ni,
  input  wire             push_i,
  output logic            full_o,
  input  wire b32_item_t  item_i,
  input  wire b32_qctl_t  qctl_i,
  output b32_qstat_t      qstat_o,
  output b32_cmd_t        cmd_o
);

  b32_cmd_t   entry_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       do_push, do_pop;
  b32_cmd_t   cmd_in;

  assign full_o        = (cnt_q == 2'd2);
  assign qstat_o.empty = (cnt_q == 2'd0);
  assign cmd_o         = entry_q[rd_ptr_q];

  assign do_push = push_i && !full_o;
  assign do_pop  = qctl_i.pop && !qstat_o.empty;

  always_comb begin
    cmd_in.prog_byte       = item_i.prog_byte;
    cmd_in.witness_version = item_i.witness_version;
    cmd_in.first_byte      = item_i.first_byte;
    cmd_in.final_byte      = item_i.final_byte;
    cmd_in.modern          = (item_i.witness_version != 5'd0);
  end

  always_comb begin
    wr_ptr_d = do_push ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = do_pop ? !rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= cmd_in;
    end
  end

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != 2'd3) else $error("queue count out of range");

  a_ptr_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 2'd0 || cnt_q == 2'd2) |-> (wr_ptr_q == rd_ptr_q))
    else $error("queue pointers disagree with count");

  a_push_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (do_push && !do_pop) |=> (cnt_q == $past(cnt_q) + 2'd1))
    else $error("accepted request not counted");

endmodule

`default_nettype wire

### hw/rtl/b32_back.sv
`default_nettype none

module b32_back import b32_pkg::*; #(
  parameter int MAX_PREFIX_CHARS = 8
) (
  input  wire              clk_i,
  input  wire              rst_ni,
  input  wire b32_cfg_t    cfg_i,
  input  wire b32_qstat_t  qstat_i,
  input  wire b32_cmd_t    cmd_i,
  output b32_qctl_t        qctl_o,
  output logic             empty_o,
  input  wire              pop_i,
  output b32_result_t      result_o
);

  localparam int IdxW = (MAX_PREFIX_CHARS > 1) ? $clog2(MAX_PREFIX_CHARS) : 1;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_PHI   = 4'd1;
  localparam logic [3:0] S_PZERO = 4'd2;
  localparam logic [3:0] S_PLO   = 4'd3;
  localparam logic [3:0] S_PCHR  = 4'd4;
  localparam logic [3:0] S_SEP   = 4'd5;
  localparam logic [3:0] S_VER   = 4'd6;
  localparam logic [3:0] S_BYTE  = 4'd7;
  localparam logic [3:0] S_SYM   = 4'd8;
  localparam logic [3:0] S_PAD   = 4'd9;
  localparam logic [3:0] S_ZERO  = 4'd10;
  localparam logic [3:0] S_CHK   = 4'd11;

  logic [3:0]      st_q, st_d;
  b32_cmd_t        cur_q, cur_d;
  logic [29:0]     acc_q, acc_d;
  logic [11:0]     buf_q, buf_d;
  logic [3:0]      cnt_q, cnt_d;
  logic            modern_q, modern_d;
  logic [IdxW-1:0] idx_q, idx_d;
  logic [2:0]      k_q, k_d;
  logic            out_valid_q, out_valid_d;
  b32_result_t     out_q, out_d;

  logic            out_free;
  logic            emit;
  logic [6:0]      emit_char;
  logic            emit_end;
  logic [IdxW-1:0] idx_last;
  logic [7:0]      pbyte;
  logic [3:0]      nc;
  logic [4:0]      sym;
  logic [29:0]     modv;
  logic [4:0]      shamt;

  assign out_free = !out_valid_q || pop_i;
  assign idx_last = IdxW'(cfg_i.len_m1);
  assign pbyte    = 8'(cfg_i.prefix_chars >> {idx_q, 3'b000});
  assign empty_o  = !out_valid_q;
  assign result_o = out_q;

  always_comb begin
    st_d       = st_q;
    cur_d      = cur_q;
    acc_d      = acc_q;
    buf_d      = buf_q;
    cnt_d      = cnt_q;
    modern_d   = modern_q;
    idx_d      = idx_q;
    k_d        = k_q;
    qctl_o.pop = 1'b0;
    emit       = 1'b0;
    emit_char  = 7'd0;
    emit_end   = 1'b0;
    nc         = cnt_q - 4'd5;
    sym        = 5'(buf_q >> nc);
    modv       = acc_q ^ (modern_q ? BECH32M_CONST : BECH32_CONST);
    shamt      = 5'd25 - 5'(k_q) * 5'd5;

    unique case (st_q)
      S_IDLE: begin
        if (!qstat_i.empty) begin
          qctl_o.pop = 1'b1;
          cur_d      = cmd_i;
          if (cmd_i.first_byte) begin
            acc_d    = CHK_INIT;
            buf_d    = 12'd0;
            cnt_d    = 4'd0;
            modern_d = cmd_i.modern;
            idx_d    = '0;
            st_d     = S_PHI;
          end else begin
            buf_d = {buf_q[3:0], cmd_i.prog_byte};
            cnt_d = cnt_q + 4'd8;
            st_d  = S_SYM;
          end
        end
      end
      S_PHI: begin
        acc_d = b32_fold(acc_q, {2'b00, pbyte[7:5]});
        idx_d = idx_q + 1'b1;
        if (idx_q == idx_last) begin
          idx_d = '0;
          st_d  = S_PZERO;
        end
      end
      S_PZERO: begin
        acc_d = b32_fold(acc_q, 5'd0);
        st_d  = S_PLO;
      end
      S_PLO: begin
        acc_d = b32_fold(acc_q, pbyte[4:0]);
        idx_d = idx_q + 1'b1;
        if (idx_q == idx_last) begin
          idx_d = '0;
          st_d  = S_PCHR;
        end
      end
      S_PCHR: begin
        if (out_free) begin
          emit      = 1'b1;
          emit_char = pbyte[6:0];
          idx_d     = idx_q + 1'b1;
          if (idx_q == idx_last) begin
            idx_d = '0;
            st_d  = S_SEP;
          end
        end
      end
      S_SEP: begin
        if (out_free) begin
          emit      = 1'b1;
          emit_char = SEPARATOR[6:0];
          st_d      = S_VER;
        end
      end
      S_VER: begin
        if (out_free) begin
          emit      = 1'b1;
          emit_char = b32_char(cur_q.witness_version);
          acc_d     = b32_fold(acc_q, cur_q.witness_version);
          st_d      = S_BYTE;
        end
      end
      S_BYTE: begin
        buf_d = {buf_q[3:0], cur_q.prog_byte};
        cnt_d = cnt_q + 4'd8;
        st_d  = S_SYM;
      end
      S_SYM: begin
        if (cnt_q >= 4'd5) begin
          if (out_free) begin
            emit      = 1'b1;
            emit_char = b32_char(sym);
            acc_d     = b32_fold(acc_q, sym);
            cnt_d     = nc;
            buf_d     = buf_q & ((12'd1 << nc) - 12'd1);
          end
        end else begin
          st_d = cur_q.final_byte ? S_PAD : S_IDLE;
        end
      end
      S_PAD: begin
        // leftover bits go out as one zero-padded symbol
        sym = 5'(buf_q << (3'd5 - cnt_q[2:0]));
        if (cnt_q == 4'd0) begin
          k_d  = 3'd0;
          st_d = S_ZERO;
        end else if (out_free) begin
          emit      = 1'b1;
          emit_char = b32_char(sym);
          acc_d     = b32_fold(acc_q, sym);
          k_d       = 3'd0;
          st_d      = S_ZERO;
        end
      end
      S_ZERO: begin
        acc_d = b32_fold(acc_q, 5'd0);
        k_d   = k_q + 3'd1;
        if (k_q == 3'd5) begin
          k_d  = 3'd0;
          st_d = S_CHK;
        end
      end
      S_CHK: begin
        sym = 5'(modv >> shamt);
        if (out_free) begin
          emit      = 1'b1;
          emit_char = b32_char(sym);
          emit_end  = (k_q == 3'd5);
          k_d       = k_q + 3'd1;
          if (k_q == 3'd5) begin
            acc_d = CHK_INIT;
            buf_d = 12'd0;
            cnt_d = 4'd0;
            k_d   = 3'd0;
            st_d  = S_IDLE;
          end
        end
      end
      default: begin
        st_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (emit) begin
      out_valid_d          = 1'b1;
      out_d.out_char       = emit_char;
      out_d.end_of_address = emit_end;
    end else if (pop_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= S_IDLE;
      acc_q       <= CHK_INIT;
      buf_q       <= 12'd0;
      cnt_q       <= 4'd0;
      modern_q    <= 1'b0;
      idx_q       <= '0;
      k_q         <= 3'd0;
      out_valid_q <= 1'b0;
    end else begin
      st_q        <= st_d;
      acc_q       <= acc_d;
      buf_q       <= buf_d;
      cnt_q       <= cnt_d;
      modern_q    <= modern_d;
      idx_q       <= idx_d;
      k_q         <= k_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
    out_q <= out_d;
  end

  a_cnt_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= 4'd12) else $error("bit count overflow");

  a_buf_masked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == S_IDLE) |-> ((buf_q >> cnt_q) == 12'd0))
    else $error("stale bits above count");

  a_take_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == S_IDLE && !qstat_i.empty) |=> (st_q != S_IDLE))
    else $error("request taken without work");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !pop_i) |-> !emit)
    else $error("result overwritten while waiting");

endmodule

`default_nettype wire

### hw/rtl/bech32_address_encoder.sv
`default_nettype none

// Channel    Direction  Handshake         Payload
// request    in         push / full       item_i   (b32_item_t)
// result     out        pop / empty       result_o (b32_result_t)
// config     in         cfg_we_i          cfg_idx_i, cfg_data_i
//
// A middle byte is taken from the input queue, then emitted as 5-bit symbols (each
// symbol being one polymod step) until fewer than five bits remain in the buffer.
// A first byte first folds and emits the prefix, then the separator and version;
// a final byte adds the pad symbol, six zero folds and the checksum.
// Reset clears all control state; the checksum restarts at 1. No clearing pass.
// A two-entry input queue and a result register let either side stall on its own.

module bech32_address_encoder import b32_pkg::*; #(
  parameter int MAX_PREFIX_CHARS = 8
) (
  input  wire              clk_i,
  input  wire              rst_ni,
  input  wire              push,
  output logic             full,
  input  wire b32_item_t   item_i,
  output logic             empty,
  input  wire              pop,
  output b32_result_t      result_o,
  input  wire              cfg_we_i,
  input  wire              cfg_idx_i,
  input  wire [63:0]       cfg_data_i
);

  logic [3:0]  prefix_length_q;
  logic [63:0] prefix_chars_q;
  logic [3:0]  len_clamped;
  b32_cfg_t    cfg;
  b32_qstat_t  qstat;
  b32_qctl_t   qctl;
  b32_cmd_t    cmd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prefix_length_q <= PREFIX_LENGTH_RST;
      prefix_chars_q  <= PREFIX_CHARS_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_PREFIX_LENGTH: prefix_length_q <= cfg_data_i[3:0];
        REG_PREFIX_CHARS:  prefix_chars_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (prefix_length_q == 4'd0) begin
      len_clamped = 4'd1;
    end else if (prefix_length_q > 4'(MAX_PREFIX_CHARS)) begin
      len_clamped = 4'(MAX_PREFIX_CHARS);
    end else begin
      len_clamped = prefix_length_q;
    end
    cfg.len_m1       = len_clamped - 4'd1;
    cfg.prefix_chars = prefix_chars_q;
  end

  b32_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .full_o  (full),
    .item_i  (item_i),
    .qctl_i  (qctl),
    .qstat_o (qstat),
    .cmd_o   (cmd)
  );

  b32_back #(
    .MAX_PREFIX_CHARS(MAX_PREFIX_CHARS)
  ) u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg),
    .qstat_i  (qstat),
    .cmd_i    (cmd),
    .qctl_o   (qctl),
    .empty_o  (empty),
    .pop_i    (pop),
    .result_o (result_o)
  );

endmodule

`default_nettype wire

### tb/sv/b32_address_checker.sv
`timescale 1ns / 100ps

module b32_address_checker import b32_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  input  logic        full_i,
  input  b32_item_t   item_i,
  input  logic        empty_i,
  input  logic        pop_i,
  input  b32_result_t result_i,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [63:0] cfg_data_i,
  output int          pending_o,
  output int          fail_count_o
);

  localparam int PREFIX_MAX = 8;
  localparam logic [29:0] BCH_GEN [5] = '{
    30'h3b6a57b2, 30'h26508e6d, 30'h1ea119fa, 30'h3d4233dd, 30'h2a1462b3
  };
  localparam logic [29:0] CLASSIC_CONST = 30'h1;
  localparam logic [29:0] MODERN_CONST  = 30'h2bc830a3;
  localparam logic [255:0] ADDR_ALPHABET = "qpzry9x8gf2tvdw0s3jn54khce6mua7l";
  localparam logic [6:0] SEP_CHAR = 7'h31;

  // predicted encoder state
  logic [29:0] chk_acc;
  logic [11:0] bit_buf;
  logic [3:0]  bit_cnt;
  logic        bech32m_sel;
  logic [3:0]  pfx_len;
  logic [63:0] pfx_chars;

  b32_result_t expected_chars [$];
  b32_result_t want;
  int          mismatches;

  function automatic logic [29:0] polymod_step(logic [29:0] acc, logic [4:0] sym);
    logic [29:0] nxt;
    nxt = {acc[24:0], sym};
    for (int k = 0; k < 5; k++) begin
      if (acc[25 + k]) begin
        nxt = nxt ^ BCH_GEN[k];
      end
    end
    return nxt;
  endfunction

  function automatic logic [6:0] alphabet_char(logic [4:0] sym);
    return ADDR_ALPHABET[8 * (31 - int'(sym)) +: 7];
  endfunction

  task automatic emit_char(input logic [6:0] c, input logic last);
    b32_result_t r;
    r.out_char       = c;
    r.end_of_address = last;
    expected_chars.push_back(r);
  endtask

  task automatic emit_symbol(input logic [4:0] sym);
    chk_acc = polymod_step(chk_acc, sym);
    emit_char(alphabet_char(sym), 1'b0);
  endtask

  task automatic predict_address_chars(input b32_item_t it);
    int          n_pfx;
    logic [4:0]  sym;
    logic [29:0] residue;
    if (it.first_byte) begin
      n_pfx = int'(pfx_len);
      if (n_pfx < 1) begin
        n_pfx = 1;
      end
      if (n_pfx > PREFIX_MAX) begin
        n_pfx = PREFIX_MAX;
      end
      chk_acc     = 30'd1;
      bit_buf     = '0;
      bit_cnt     = '0;
      bech32m_sel = (it.witness_version != 5'd0);
      // prefix expansion: high parts, zero, low parts (full 8-bit bytes)
      for (int i = 0; i < n_pfx; i++) begin
        chk_acc = polymod_step(chk_acc, {2'b00, pfx_chars[8 * i + 5 +: 3]});
      end
      chk_acc = polymod_step(chk_acc, 5'd0);
      for (int i = 0; i < n_pfx; i++) begin
        chk_acc = polymod_step(chk_acc, pfx_chars[8 * i +: 5]);
      end
      for (int i = 0; i < n_pfx; i++) begin
        emit_char(pfx_chars[8 * i +: 7], 1'b0);
      end
      emit_char(SEP_CHAR, 1'b0);
      emit_symbol(it.witness_version);
    end

    bit_buf = {bit_buf[3:0], it.prog_byte};
    bit_cnt = bit_cnt + 4'd8;
    while (bit_cnt >= 4'd5) begin
      bit_cnt = bit_cnt - 4'd5;
      sym = 5'(bit_buf >> bit_cnt);
      emit_symbol(sym);
    end
    bit_buf = bit_buf & ((12'd1 << bit_cnt) - 12'd1);

    if (it.final_byte) begin
      if (bit_cnt != 4'd0) begin
        sym = 5'(bit_buf << (5 - int'(bit_cnt)));
        emit_symbol(sym);
      end
      repeat (6) chk_acc = polymod_step(chk_acc, 5'd0);
      residue = chk_acc ^ (bech32m_sel ? MODERN_CONST : CLASSIC_CONST);
      for (int k = 0; k < 6; k++) begin
        sym = 5'(residue >> (5 * (5 - k)));
        emit_char(alphabet_char(sym), k == 5);
      end
      chk_acc = 30'd1;
      bit_buf = '0;
      bit_cnt = '0;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chk_acc     = 30'd1;
      bit_buf     = '0;
      bit_cnt     = '0;
      bech32m_sel = 1'b0;
      pfx_len     = 4'd2;
      pfx_chars   = 64'd25442;
      mismatches  = 0;
      expected_chars.delete();
      pending_o    <= 0;
      fail_count_o <= 0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == REG_PREFIX_LENGTH) begin
          pfx_len = cfg_data_i[3:0];
        end else begin
          pfx_chars = cfg_data_i;
        end
      end
      if (push_i && !full_i) begin
        predict_address_chars(item_i);
      end
      if (pop_i && !empty_i) begin
        if (expected_chars.size() == 0) begin
          $error("unexpected result: out_char %0h end_of_address %0b",
                 result_i.out_char, result_i.end_of_address);
          mismatches++;
        end else begin
          want = expected_chars.pop_front();
          if (result_i.out_char !== want.out_char) begin
            $error("out_char: expected %0h, got %0h", want.out_char, result_i.out_char);
            mismatches++;
          end
          if (result_i.end_of_address !== want.end_of_address) begin
            $error("end_of_address: expected %0b, got %0b",
                   want.end_of_address, result_i.end_of_address);
            mismatches++;
          end
        end
      end
      pending_o    <= expected_chars.size();
      fail_count_o <= mismatches;
    end
  end

endmodule

### tb/sv/tb_bech32_address_encoder.sv
`timescale 1ns / 100ps

module tb_bech32_address_encoder;
  import b32_pkg::*;

  logic        clk      = 1'b0;
  logic        rst_n    = 1'b0;
  logic        push     = 1'b0;
  logic        full;
  b32_item_t   req_item = '0;
  logic        empty;
  logic        pop      = 1'b0;
  b32_result_t result;
  logic        cfg_we   = 1'b0;
  logic        cfg_idx  = REG_PREFIX_LENGTH;
  logic [63:0] cfg_data = '0;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int pending;
  int fail_count;
  int random_items = 0;

  bech32_address_encoder uut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .push       (push),
    .full       (full),
    .item_i     (req_item),
    .empty      (empty),
    .pop        (pop),
    .result_o   (result),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  b32_address_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .push_i       (push),
    .full_i       (full),
    .item_i       (req_item),
    .empty_i      (empty),
    .pop_i        (pop),
    .result_i     (result),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_data_i   (cfg_data),
    .pending_o    (pending),
    .fail_count_o (fail_count)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    pop <= ($urandom_range(99) >= recv_idle_pct);
  end

  function automatic b32_item_t build_request(logic [7:0] b, logic [4:0] v, logic f, logic l);
    b32_item_t r;
    r.prog_byte       = b;
    r.witness_version = v;
    r.first_byte      = f;
    r.final_byte      = l;
    return r;
  endfunction

  // push stays high across back-to-back requests
  task automatic send_item(input b32_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push     <= 1'b1;
    req_item <= it;
    @(posedge clk);
    while (full) @(posedge clk);
  endtask

  // hold off until every predicted char is out, then let the block settle
  task automatic drain_results;
    push <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  task automatic write_prefix(input logic [3:0] len, input logic [63:0] chars);
    logic [63:0] len_word;
    len_word      = {$urandom, $urandom};
    len_word[3:0] = len;
    cfg_we   <= 1'b1;
    cfg_idx  <= REG_PREFIX_LENGTH;
    cfg_data <= len_word;
    @(posedge clk);
    cfg_idx  <= REG_PREFIX_CHARS;
    cfg_data <= chars;
    @(posedge clk);
    cfg_we   <= 1'b0;
  endtask

  task automatic send_address(input logic [4:0] ver, input int nbytes, input logic closed);
    b32_item_t it;
    for (int i = 0; i < nbytes; i++) begin
      it.prog_byte       = 8'($urandom_range(255));
      it.witness_version = (i == 0) ? ver : 5'($urandom_range(31));
      it.first_byte      = (i == 0);
      it.final_byte      = closed && (i == nbytes - 1);
      send_item(it);
      random_items++;
    end
  endtask

  task automatic random_traffic(input int n_items);
    int         stop_at;
    int         kind;
    int         pick;
    int         nbytes;
    logic [4:0] ver;
    b32_item_t  it;
    stop_at = random_items + n_items;
    while (random_items < stop_at) begin
      kind = $urandom_range(99);
      pick = $urandom_range(9);
      if (pick < 4) begin
        ver = 5'd0;
      end else if (pick < 9) begin
        ver = 5'($urandom_range(16, 1));
      end else begin
        ver = 5'($urandom_range(31, 17));
      end
      pick = $urandom_range(19);
      if (pick < 16) begin
        nbytes = $urandom_range(8, 1);
      end else if (pick < 19) begin
        nbytes = $urandom_range(20, 9);
      end else begin
        nbytes = 32;
      end
      if (kind < 82) begin
        send_address(ver, nbytes, 1'b1);
      end else if (kind < 92) begin
        // stray byte, no first marker
        it            = b32_item_t'($urandom);
        it.first_byte = 1'b0;
        send_item(it);
        random_items++;
      end else begin
        // abandoned address, restarted by a later first byte
        send_address(ver, $urandom_range(4, 1), 1'b0);
      end
    end
  endtask

  task automatic random_prefix;
    logic [3:0] len;
    case ($urandom_range(5))
      0:       len = 4'd0;
      1:       len = 4'd1;
      2:       len = 4'd8;
      3:       len = 4'd15;
      4:       len = 4'($urandom_range(7, 2));
      default: len = 4'($urandom_range(14, 9));
    endcase
    write_prefix(len, {$urandom, $urandom});
  endtask

  initial begin
    #5_000_000;
    $display("FAILURE");
    $finish;
  end

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    send_idle_pct = 14;
    recv_idle_pct = 65;
    @(posedge clk);

    // bytes before any first byte continue from reset state
    send_item(build_request(8'h00, 5'd0, 1'b0, 1'b0));
    send_item(build_request(8'hff, 5'd0, 1'b0, 1'b1));
    // version 0 address, default prefix
    send_item(build_request(8'h00, 5'd0, 1'b1, 1'b0));
    send_item(build_request(8'hff, 5'd0, 1'b0, 1'b0));
    send_item(build_request(8'ha5, 5'd0, 1'b0, 1'b1));
    // single-byte address, top legal version
    send_item(build_request(8'hff, 5'd16, 1'b1, 1'b1));
    // version above 16
    send_item(build_request(8'h00, 5'd31, 1'b1, 1'b0));
    send_item(build_request(8'h80, 5'd0, 1'b0, 1'b1));
    // after a final byte the variant sticks for a stray byte
    send_item(build_request(8'h5a, 5'd0, 1'b0, 1'b1));
    // restart while bits are still buffered
    send_item(build_request(8'h12, 5'd1, 1'b1, 1'b0));
    send_item(build_request(8'h34, 5'd0, 1'b0, 1'b0));
    send_item(build_request(8'h56, 5'd0, 1'b1, 1'b0));
    send_item(build_request(8'h78, 5'd0, 1'b0, 1'b1));

    // zero length taken as one, prefix bytes with bit 7 set
    drain_results();
    write_prefix(4'd0, '1);
    send_item(build_request(8'h00, 5'd0, 1'b1, 1'b1));
    // length above max is clamped
    drain_results();
    write_prefix(4'd15, 64'h8081_c3e7_7f41_6210);
    send_item(build_request(8'hff, 5'd5, 1'b1, 1'b1));
    drain_results();
    write_prefix(4'd8, 64'h6867_6665_6463_6261);
    send_item(build_request(8'h3c, 5'd0, 1'b1, 1'b0));
    send_item(build_request(8'hc3, 5'd0, 1'b0, 1'b1));
    drain_results();
    write_prefix(4'd1, 64'h0000_0000_0000_0074);
    send_item(build_request(8'h96, 5'd1, 1'b1, 1'b1));

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 14;
          recv_idle_pct = 65;
        end
        1: begin
          send_idle_pct = 65;
          recv_idle_pct = 14;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      for (int half = 0; half < 2; half++) begin
        drain_results();
        random_prefix();
        random_traffic(12);
      end
    end

    drain_results();
    if (fail_count == 0 && pending == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

### filelist.f
hw/rtl/b32_pkg.sv
hw/rtl/b32_front.sv
hw/rtl/b32_back.sv
hw/rtl/bech32_address_encoder.sv
tb/sv/b32_address_checker.sv
tb/sv/tb_bech32_address_encoder.sv
